// ===== hw/rtl/hpa_pkg.sv =====
`default_nettype none
package hpa_pkg;
	localparam int CODE_BITS_DEF     = 12;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRAC_SHIFT        = 20;
	localparam int CW                = 40;
	localparam int AW                = 24;
	localparam logic signed [AW-1:0] PI_Q20 = 24'sd3294199;
	localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754936;
	localparam logic signed [15:0] RAD_LIMIT = 16'sd25736;
	localparam logic signed [15:0] DEG_LIMIT = 16'sd11520;
	localparam int DIV_STEPS = 17;

	localparam logic [0:0] REG_ZERO_CODE = 1'b0;
	localparam logic [0:0] REG_DEGREE    = 1'b1;

	function automatic logic signed [AW-1:0] atan_q20(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 24'sd823550;  1: r = 24'sd486170;  2: r = 24'sd256879;
			3: r = 24'sd130396;  4: r = 24'sd65451;   5: r = 24'sd32757;
			6: r = 24'sd16383;   7: r = 24'sd8192;    8: r = 24'sd4096;
			9: r = 24'sd2048;    10: r = 24'sd1024;   11: r = 24'sd512;
			12: r = 24'sd256;    13: r = 24'sd128;    14: r = 24'sd64;
			15: r = 24'sd32;     16: r = 24'sd16;     17: r = 24'sd8;
			18: r = 24'sd4;      19: r = 24'sd2;      20: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic                 neg;
		logic                 deg;
		logic                 none;
		logic signed [16:0]   xc;
		logic signed [16:0]   yc;
	} hpa_side_t;
endpackage
`default_nettype wire

// ===== hw/rtl/hpa_div_cell.sv =====
`default_nettype none
// One restoring division step; quotient bits shift in from the right.
module hpa_div_cell (
	input  wire logic        clk,
	input  wire logic        vld_i,
	input  wire logic [33:0] rem_i,
	input  wire logic [16:0] den_i,
	input  wire logic [16:0] quo_i,
	input  wire logic [32:0] num_i,
	input  wire hpa_pkg::hpa_side_t side_i,
	output logic             vld_o,
	output logic [33:0]      rem_o,
	output logic [16:0]      den_o,
	output logic [16:0]      quo_o,
	output logic [32:0]      num_o,
	output hpa_pkg::hpa_side_t side_o,
	input  wire logic        arst_n,
	input  wire logic        en
);
	import hpa_pkg::*;
	logic [33:0] tr;
	logic        ge;
	always_comb begin
		tr = {rem_i[32:0], num_i[32]};
		ge = tr >= {17'd0, den_i};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_o <= 1'b0;
		else if (en) vld_o <= vld_i;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? tr - {17'd0, den_i} : tr;
			quo_o  <= {quo_i[15:0], ge};
			num_o  <= {num_i[31:0], 1'b0};
			den_o  <= den_i;
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/hpa_cordic_cell.sv =====
`default_nettype none
// One vectoring rotation; the accumulator is updated and the flags ride along.
module hpa_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic vld_i,
	input  wire logic signed [hpa_pkg::CW-1:0] x_i,
	input  wire logic signed [hpa_pkg::CW-1:0] y_i,
	input  wire logic signed [hpa_pkg::AW-1:0] acc_i,
	input  wire hpa_pkg::hpa_side_t side_i,
	output logic vld_o,
	output logic signed [hpa_pkg::CW-1:0] x_o,
	output logic signed [hpa_pkg::CW-1:0] y_o,
	output logic signed [hpa_pkg::AW-1:0] acc_o,
	output hpa_pkg::hpa_side_t side_o
);
	import hpa_pkg::*;
	logic signed [CW-1:0] xs, ys;
	// Shift truncating toward zero
	always_comb begin
		xs = (x_i < 0) ? -((-x_i) >>> IDX) : (x_i >>> IDX);
		ys = (y_i < 0) ? -((-y_i) >>> IDX) : (y_i >>> IDX);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_o <= 1'b0;
		else if (en) vld_o <= vld_i;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			if (y_i >= 0) begin
				x_o <= x_i + ys; y_o <= y_i - xs; acc_o <= acc_i + atan_q20(IDX);
			end else begin
				x_o <= x_i - ys; y_o <= y_i + xs; acc_o <= acc_i - atan_q20(IDX);
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/hall_pair_angle.sv =====
`default_nettype none
// Channel   Handshake        Payload
// in        valid / stall    x_sample, y_sample
// out       out_valid/out_stall angle, x_centered, y_centered, no_field
// cfg       cfg_valid/ready  cfg_index, cfg_data
// One item per cycle while the output does not stall; the path runs through
// the input stage, the DIV_STEPS (17) restoring divider cells (both channels side by side),
// the pre-rotation stage, the CORDIC cells, the degree multiply and the output.
// arst_n clears all valid flags and sets the configuration registers to their reset values.
// A stall on the output freezes the whole chain; stall on input follows it.
module hall_pair_angle #(
	parameter int CODE_BITS     = hpa_pkg::CODE_BITS_DEF,
	parameter int CORDIC_STAGES = hpa_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid,
	output logic      stall,
	input  wire logic [11:0] x_sample,
	input  wire logic [11:0] y_sample,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic signed [15:0] angle,
	output logic signed [12:0] x_centered,
	output logic signed [12:0] y_centered,
	output logic      no_field,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [0:0] cfg_index,
	input  wire logic [11:0] cfg_data
);
	import hpa_pkg::*;
	localparam int FULL = (1 << CODE_BITS) - 1;
	localparam int NCH = 2;
	localparam int DS = DIV_STEPS;

	logic [11:0] zero_q;
	logic        deg_q;
	logic        en;
	assign en = !(out_valid && out_stall);
	assign stall = !en;
	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 12'd2048; deg_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ZERO_CODE: zero_q <= cfg_data;
				REG_DEGREE:    deg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1: clamp, form numerators range*(z-v)
	logic [16:0] zc;
	logic [16:0] vc [NCH];
	logic [16:0] rng;
	logic        vld_s1;
	logic [16:0] den_s1;
	logic [32:0] num_s1 [NCH];
	logic        below_s1 [NCH];
	logic signed [16:0] pos_s1 [NCH];
	logic        deg_s1;
	always_comb begin
		zc = ({5'd0, zero_q} > 17'(FULL)) ? 17'(FULL) : {5'd0, zero_q};
		vc[0] = ({5'd0, x_sample} > 17'(FULL)) ? 17'(FULL) : {5'd0, x_sample};
		vc[1] = ({5'd0, y_sample} > 17'(FULL)) ? 17'(FULL) : {5'd0, y_sample};
		rng = 17'(FULL) - zc;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			den_s1 <= (zc == 17'd0) ? 17'd1 : zc;
			deg_s1 <= deg_q;
			for (int c = 0; c < NCH; c++) begin
				below_s1[c] <= vc[c] < zc;
				pos_s1[c]   <= (vc[c] > zc) ? $signed(vc[c] - zc) : 17'sd0;
				num_s1[c]   <= 33'(rng) * 33'(zc - vc[c]);
			end
		end
	end

	// Divider chains, one per channel; each chain carries its own side data
	logic        dv [NCH][DS+1];
	logic [33:0] rm [NCH][DS+1];
	logic [16:0] dn [NCH][DS+1];
	logic [16:0] qo [NCH][DS+1];
	logic [32:0] nm [NCH][DS+1];
	hpa_side_t   sd [NCH][DS+1];
	genvar c, k;
	generate
		for (c = 0; c < NCH; c++) begin : g_ch
			// Seed the remainder with the upper numerator bits, feed the rest
			assign dv[c][0] = vld_s1;
			assign rm[c][0] = {18'd0, num_s1[c][32:17]};
			assign dn[c][0] = den_s1;
			assign qo[c][0] = '0;
			assign nm[c][0] = num_s1[c] << 16;
			assign sd[c][0] = '{neg: below_s1[c], deg: deg_s1, none: 1'b0,
				xc: pos_s1[c], yc: 17'sd0};
			for (k = 0; k < DS; k++) begin : g_div
				hpa_div_cell u_div (
					.clk(clk), .vld_i(dv[c][k]), .rem_i(rm[c][k]), .den_i(dn[c][k]),
					.quo_i(qo[c][k]), .num_i(nm[c][k]), .side_i(sd[c][k]),
					.vld_o(dv[c][k+1]), .rem_o(rm[c][k+1]), .den_o(dn[c][k+1]),
					.quo_o(qo[c][k+1]), .num_o(nm[c][k+1]), .side_o(sd[c][k+1]),
					.arst_n(arst_n), .en(en));
			end
		end
	endgenerate

	// Stage 2: pick centred values, pre-rotate into the right half plane
	logic signed [16:0] xcv, ycv;
	always_comb begin
		xcv = sd[0][DS].neg ? -$signed(qo[0][DS]) : sd[0][DS].xc;
		ycv = sd[1][DS].neg ? -$signed(qo[1][DS]) : sd[1][DS].xc;
	end
	logic vld_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic signed [AW-1:0] acc_s2;
	hpa_side_t side_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= dv[0][DS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= '{neg: 1'b0, deg: sd[0][DS].deg,
				none: (xcv == 0) && (ycv == 0), xc: xcv, yc: ycv};
			if (xcv < 0) begin
				x_s2 <= -(CW'(xcv) <<< FRAC_SHIFT);
				y_s2 <= -(CW'(ycv) <<< FRAC_SHIFT);
				acc_s2 <= (ycv >= 0) ? PI_Q20 : -PI_Q20;
			end else begin
				x_s2 <= CW'(xcv) <<< FRAC_SHIFT;
				y_s2 <= CW'(ycv) <<< FRAC_SHIFT;
				acc_s2 <= '0;
			end
		end
	end

	// CORDIC chain
	logic cv [CORDIC_STAGES+1];
	logic signed [CW-1:0] cx [CORDIC_STAGES+1];
	logic signed [CW-1:0] cy [CORDIC_STAGES+1];
	logic signed [AW-1:0] ca [CORDIC_STAGES+1];
	hpa_side_t cs [CORDIC_STAGES+1];
	assign cv[0] = vld_s2; assign cx[0] = x_s2; assign cy[0] = y_s2;
	assign ca[0] = acc_s2; assign cs[0] = side_s2;
	generate
		for (k = 0; k < CORDIC_STAGES; k++) begin : g_cor
			hpa_cordic_cell #(.IDX(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en), .vld_i(cv[k]), .x_i(cx[k]),
				.y_i(cy[k]), .acc_i(ca[k]), .side_i(cs[k]), .vld_o(cv[k+1]),
				.x_o(cx[k+1]), .y_o(cy[k+1]), .acc_o(ca[k+1]), .side_o(cs[k+1]));
		end
	endgenerate

	// Stage 3: degree multiply on magnitude
	localparam int CS = CORDIC_STAGES;
	logic vld_s3;
	logic [22:0] mag_s3;
	logic [44:0] prod_s3;
	logic sgn_s3;
	hpa_side_t side_s3;
	logic [22:0] amag;
	assign amag = (ca[CS] < 0) ? 23'(-ca[CS]) : 23'(ca[CS]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= cv[CS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= amag; sgn_s3 <= ca[CS] < 0; side_s3 <= cs[CS];
			prod_s3 <= 45'(amag) * 45'(DEG_PER_RAD_Q16);
		end
	end

	// Stage 4: round, saturate, output register
	logic [22:0] rmag;
	logic [15:0] lim;
	logic [15:0] smag;
	always_comb begin
		rmag = side_s3.deg ? 23'((prod_s3 + (45'd1 << 29)) >> 30)
			: 23'((mag_s3 + 23'd64) >> 7);
		lim = side_s3.deg ? DEG_LIMIT : RAD_LIMIT;
		smag = (rmag > 23'(lim)) ? lim : rmag[15:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			angle <= side_s3.none ? 16'sd0 : (sgn_s3 ? -$signed(smag) : $signed(smag));
			x_centered <= side_s3.xc[12:0];
			y_centered <= side_s3.yc[12:0];
			no_field <= side_s3.none;
		end
	end

	ap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_field |-> angle == 16'sd0) else $error("angle not zero");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle)) else $error("output moved");
	ap_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> out_valid) else $error("stall without output");
endmodule
`default_nettype wire
